[hdl/sgi_pkg.sv]
// Shared widths and types for the 2D segment intersection pipeline.
`default_nettype none
package sgi_pkg;

	localparam int COORD_BITS = 24;
	localparam int QUOT_BITS  = 16;
	localparam int DIF_W      = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int REM_W      = CROSS_W + 1;
	localparam int Q_W        = QUOT_BITS + 1;
	localparam int DIV_STAGES = QUOT_BITS + 1;
	localparam int PX_W       = Q_W + 1 + DIF_W;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIF_W-1:0]      dif_t;

	typedef struct packed {
		logic   hit;
		coord_t ax;
		coord_t ay;
		dif_t   rx;
		dif_t   ry;
	} side_t;

endpackage
`default_nettype wire

[hdl/sgi_front.sv]
// Front end: differences, cross products, sign fold and range test.
`default_nettype none
module sgi_front import sgi_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire coord_t                a_start_x,
	input  wire coord_t                a_start_y,
	input  wire coord_t                a_end_x,
	input  wire coord_t                a_end_y,
	input  wire coord_t                b_start_x,
	input  wire coord_t                b_start_y,
	input  wire coord_t                b_end_x,
	input  wire coord_t                b_end_y,
	output logic                       valid,
	output side_t                      side,
	output logic [CROSS_W-1:0]         t_mag,
	output logic [CROSS_W-1:0]         d_mag
);

	logic  v_s1, v_s2, v_s3, v_s4;
	dif_t  rx_s1, ry_s1, ux_s1, uy_s1, wx_s1, wy_s1;
	coord_t ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	dif_t  rx_s2, ry_s2, rx_s3, ry_s3;
	logic signed [PROD_W-1:0] p_rxuy_s2, p_uxry_s2, p_rxwy_s2, p_rywx_s2, p_uxwy_s2, p_uywx_s2;
	logic signed [CROSS_W-1:0] d_s3, s_s3, t_s3;
	logic signed [CROSS_W-1:0] dn, sn, tn;
	logic hit_c;
	side_t side_s4;
	logic [CROSS_W-1:0] t_s4, d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s1 <= DIF_W'(a_end_x) - DIF_W'(a_start_x);
			ry_s1 <= DIF_W'(a_end_y) - DIF_W'(a_start_y);
			ux_s1 <= DIF_W'(b_end_x) - DIF_W'(b_start_x);
			uy_s1 <= DIF_W'(b_end_y) - DIF_W'(b_start_y);
			wx_s1 <= DIF_W'(a_start_x) - DIF_W'(b_start_x);
			wy_s1 <= DIF_W'(a_start_y) - DIF_W'(b_start_y);
			ax_s1 <= a_start_x;
			ay_s1 <= a_start_y;

			p_rxuy_s2 <= PROD_W'(rx_s1) * PROD_W'(uy_s1);
			p_uxry_s2 <= PROD_W'(ux_s1) * PROD_W'(ry_s1);
			p_rxwy_s2 <= PROD_W'(rx_s1) * PROD_W'(wy_s1);
			p_rywx_s2 <= PROD_W'(ry_s1) * PROD_W'(wx_s1);
			p_uxwy_s2 <= PROD_W'(ux_s1) * PROD_W'(wy_s1);
			p_uywx_s2 <= PROD_W'(uy_s1) * PROD_W'(wx_s1);
			rx_s2 <= rx_s1;
			ry_s2 <= ry_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;

			d_s3  <= CROSS_W'(p_rxuy_s2) - CROSS_W'(p_uxry_s2);
			s_s3  <= CROSS_W'(p_rxwy_s2) - CROSS_W'(p_rywx_s2);
			t_s3  <= CROSS_W'(p_uxwy_s2) - CROSS_W'(p_uywx_s2);
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;

			side_s4 <= '{hit: hit_c, ax: ax_s3, ay: ay_s3, rx: rx_s3, ry: ry_s3};
			t_s4    <= CROSS_W'(tn);
			d_s4    <= CROSS_W'(dn);
		end
	end

	// fold the sign of d into all three so the range test is against a positive d
	always_comb begin
		if (d_s3[CROSS_W-1]) begin
			dn = -d_s3;
			sn = -s_s3;
			tn = -t_s3;
		end else begin
			dn = d_s3;
			sn = s_s3;
			tn = t_s3;
		end
		hit_c = (d_s3 != '0) && !sn[CROSS_W-1] && (sn <= dn) && !tn[CROSS_W-1] && (tn <= dn);
	end

	assign valid = v_s4;
	assign side  = side_s4;
	assign t_mag = t_s4;
	assign d_mag = d_s4;

`ifndef NO_ASSERTIONS
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && side_s4.hit |-> (d_s4 != '0) && (t_s4 <= d_s4))
		else $error("hit flagged with t outside [0,d]");
`endif

endmodule
`default_nettype wire

[hdl/sgi_div.sv]
// Pipelined restoring divider: one quotient bit per stage, side data alongside.
`default_nettype none
module sgi_div import sgi_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire side_t                 in_side,
	input  wire logic [CROSS_W-1:0]    t_mag,
	input  wire logic [CROSS_W-1:0]    d_mag,
	output logic                       valid,
	output side_t                      side,
	output logic [Q_W-1:0]             quot
);

	logic              v_s   [DIV_STAGES];
	side_t             sd_s  [DIV_STAGES];
	logic [REM_W-1:0]  rem_s [DIV_STAGES];
	logic [REM_W-1:0]  d_s   [DIV_STAGES];
	logic [Q_W-1:0]    q_s   [DIV_STAGES];

	logic [REM_W-1:0]  rem_n [DIV_STAGES];
	logic [Q_W-1:0]    q_n   [DIV_STAGES];

	always_comb begin
		logic [REM_W-1:0] sh;
		logic [REM_W-1:0] d0;
		sh = '0;
		d0 = REM_W'(d_mag);
		// first step: integer bit of the quotient (t may equal d)
		if (REM_W'(t_mag) >= d0) begin
			rem_n[0] = REM_W'(t_mag) - d0;
			q_n[0]   = Q_W'(1);
		end else begin
			rem_n[0] = REM_W'(t_mag);
			q_n[0]   = '0;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			sh = rem_s[k-1] << 1;
			if (sh >= d_s[k-1]) begin
				rem_n[k] = sh - d_s[k-1];
				q_n[k]   = {q_s[k-1][Q_W-2:0], 1'b1};
			end else begin
				rem_n[k] = sh;
				q_n[k]   = {q_s[k-1][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < DIV_STAGES; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s[0]  <= in_side;
			d_s[0]   <= REM_W'(d_mag);
			rem_s[0] <= rem_n[0];
			q_s[0]   <= q_n[0];
			for (int k = 1; k < DIV_STAGES; k++) begin
				sd_s[k]  <= sd_s[k-1];
				d_s[k]   <= d_s[k-1];
				rem_s[k] <= rem_n[k];
				q_s[k]   <= q_n[k];
			end
		end
	end

	assign valid = v_s[DIV_STAGES-1];
	assign side  = sd_s[DIV_STAGES-1];
	assign quot  = q_s[DIV_STAGES-1];

`ifndef NO_ASSERTIONS
	a_rem_below_d: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[DIV_STAGES-1] && sd_s[DIV_STAGES-1].hit |->
			rem_s[DIV_STAGES-1] < d_s[DIV_STAGES-1])
		else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

[hdl/segment_intersection_2d_unit.sv]
// Top level: 2D segment intersection, fully pipelined, one pair per cycle while not stalled.
// Pipeline order from input transfer to result valid: front end, divider, back end.
// Throughput: one transfer per cycle; a new pair enters every cycle the output is not stalled.
// The whole pipeline advances on one enable, so an output stall holds every stage in place.
// Reset (arst_n low, asynchronous): all stage valid bits clear; no payload reset.
// The divider depth (one stage per quotient bit plus the integer bit) sets the latency.
`default_nettype none
module segment_intersection_2d_unit import sgi_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire coord_t a_start_x,
	input  wire coord_t a_start_y,
	input  wire coord_t a_end_x,
	input  wire coord_t a_end_y,
	input  wire coord_t b_start_x,
	input  wire coord_t b_start_y,
	input  wire coord_t b_end_x,
	input  wire coord_t b_end_y,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic        hit,
	output coord_t      hit_x,
	output coord_t      hit_y
);

	// advance everything unless a finished result is being held at the output
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic               f_valid;
	side_t              f_side;
	logic [CROSS_W-1:0] f_t, f_d;

	sgi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.valid     (f_valid),
		.side      (f_side),
		.t_mag     (f_t),
		.d_mag     (f_d)
	);

	logic           q_valid;
	side_t          q_side;
	logic [Q_W-1:0] q_val;

	// on a hit, quotient q = floor(|t| * 2^16 / |d|), in [0, 2^16]
	sgi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (f_valid),
		.in_side  (f_side),
		.t_mag    (f_t),
		.d_mag    (f_d),
		.valid    (q_valid),
		.side     (q_side),
		.quot     (q_val)
	);

	// back end: scale direction A by q, then floor-shift and add start A
	logic                   v_m, v_o;
	side_t                  sd_m;
	logic [Q_W-1:0]         q_m;
	logic signed [PX_W-1:0] px_m, py_m;
	logic signed [PX_W-1:0] sum_x, sum_y;
	logic                   hit_o;
	coord_t                 x_o, y_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
			v_o <= 1'b0;
		end else if (adv) begin
			v_m <= q_valid;
			v_o <= v_m;
		end
	end

	always_comb begin
		// arithmetic shift gives the floor, matching rounding toward minus infinity
		sum_x = PX_W'(sd_m.ax) + (px_m >>> QUOT_BITS);
		sum_y = PX_W'(sd_m.ay) + (py_m >>> QUOT_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_m  <= q_side;
			q_m   <= q_val;
			px_m  <= PX_W'($signed({1'b0, q_val})) * PX_W'(q_side.rx);
			py_m  <= PX_W'($signed({1'b0, q_val})) * PX_W'(q_side.ry);
			hit_o <= sd_m.hit;
			// drop the point on a miss
			x_o   <= sd_m.hit ? sum_x[COORD_BITS-1:0] : '0;
			y_o   <= sd_m.hit ? sum_y[COORD_BITS-1:0] : '0;
		end
	end

	assign out_valid = v_o;
	assign hit       = hit_o;
	assign hit_x     = x_o;
	assign hit_y     = y_o;

`ifndef NO_ASSERTIONS
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_m && sd_m.hit |-> q_m <= Q_W'(1 << QUOT_BITS))
		else $error("quotient above one");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (hit_x == '0) && (hit_y == '0))
		else $error("miss with nonzero point");
`endif

endmodule
`default_nettype wire

[tb/tb_segment_intersection_2d_unit.sv]
// Testbench for the 2D segment intersection unit: random and directed pairs, scoreboard check.
`default_nettype none
module tb_segment_intersection_2d_unit;
	import sgi_pkg::*;

	// One expected intersection result.
	typedef struct {
		logic   hit;
		coord_t x;
		coord_t y;
	} isect_t;

	// Predict the intersection of one segment pair.
	function automatic isect_t predict_isect(coord_t ax, coord_t ay, coord_t ex, coord_t ey,
			coord_t bx, coord_t by, coord_t fx, coord_t fy);
		isect_t res;
		logic signed [63:0] rx, ry, ux, uy, wx, wy, px, py;
		logic signed [127:0] d, s, t, rem;
		logic signed [63:0] q;
		res.hit = 1'b0;
		res.x = '0;
		res.y = '0;
		rx = 64'(ex) - 64'(ax);
		ry = 64'(ey) - 64'(ay);
		ux = 64'(fx) - 64'(bx);
		uy = 64'(fy) - 64'(by);
		wx = 64'(ax) - 64'(bx);
		wy = 64'(ay) - 64'(by);
		d = 128'(rx) * 128'(uy) - 128'(ux) * 128'(ry);
		s = 128'(rx) * 128'(wy) - 128'(ry) * 128'(wx);
		t = 128'(ux) * 128'(wy) - 128'(uy) * 128'(wx);
		if (d == 0)
			return res;
		if (d < 0) begin
			d = -d;
			s = -s;
			t = -t;
		end
		if (s < 0 || s > d || t < 0 || t > d)
			return res;
		// restoring division, one integer bit plus QUOT_BITS fraction bits
		rem = t;
		q = 0;
		if (rem >= d) begin
			q = 1;
			rem = rem - d;
		end
		for (int i = 0; i < QUOT_BITS; i++) begin
			rem = rem <<< 1;
			q = q <<< 1;
			if (rem >= d) begin
				rem = rem - d;
				q = q | 1;
			end
		end
		// arithmetic shift floors toward minus infinity
		px = (q * rx) >>> QUOT_BITS;
		py = (q * ry) >>> QUOT_BITS;
		res.hit = 1'b1;
		res.x = coord_t'(64'(ax) + px);
		res.y = coord_t'(64'(ay) + py);
		return res;
	endfunction

	// Scoreboard: hold predicted results in order of transfer.
	class isect_board;
		isect_t pending[$];
		int errors;

		function void note_pair(coord_t ax, coord_t ay, coord_t ex, coord_t ey,
				coord_t bx, coord_t by, coord_t fx, coord_t fy);
			pending.push_back(predict_isect(ax, ay, ex, ey, bx, by, fx, fy));
		endfunction

		function void check_result(logic h, coord_t x, coord_t y);
			isect_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result hit=%0d x=%0d y=%0d", $time, h, x, y);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (h !== e.hit) begin
				$display("%0t: hit expected %0d actual %0d", $time, e.hit, h);
				errors++;
			end
			if (x !== e.x) begin
				$display("%0t: hit_x expected %0d actual %0d", $time, e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$display("%0t: hit_y expected %0d actual %0d", $time, e.y, y);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY   = 23;
	localparam int WDOG_MAX  = 5000;
	localparam int N_RANDOM  = 1700;

	logic   clk, arst_n;
	logic   in_valid, in_stall, out_valid, out_stall, hit;
	coord_t a_start_x, a_start_y, a_end_x, a_end_y;
	coord_t b_start_x, b_start_y, b_end_x, b_end_y;
	coord_t hit_x, hit_y;

	isect_board board;
	bit calm;        // stretch with no idling on either side
	bit stim_done;
	int idle_cycles;

	segment_intersection_2d_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_start_x(a_start_x), .a_start_y(a_start_y),
		.a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y),
		.b_end_x(b_end_x), .b_end_y(b_end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_x(hit_x), .hit_y(hit_y)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Random coordinate: mostly small so segments meet often, sometimes full range.
	function automatic coord_t rand_coord(int span);
		if ($urandom_range(0, 9) == 0)
			return coord_t'($urandom);
		return coord_t'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// Drive one pair and hold it until the transfer happens; drop valid only while idling.
	task automatic send_pair(coord_t ax, coord_t ay, coord_t ex, coord_t ey,
			coord_t bx, coord_t by, coord_t fx, coord_t fy);
		while (!calm && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		a_start_x <= ax;
		a_start_y <= ay;
		a_end_x   <= ex;
		a_end_y   <= ey;
		b_start_x <= bx;
		b_start_y <= by;
		b_end_x   <= fx;
		b_end_y   <= fy;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_pair(ax, ay, ex, ey, bx, by, fx, fy);
	endtask

	// Crossing pair built around a chosen point, so most random pairs hit.
	task automatic send_crossing(int span);
		coord_t cx, cy;
		int dx1, dy1, dx2, dy2;
		cx  = rand_coord(span);
		cy  = rand_coord(span);
		dx1 = $signed($urandom_range(0, 2 * span)) - span;
		dy1 = $signed($urandom_range(0, 2 * span)) - span;
		dx2 = $signed($urandom_range(0, 2 * span)) - span;
		dy2 = $signed($urandom_range(0, 2 * span)) - span;
		send_pair(coord_t'(cx - dx1), coord_t'(cy - dy1), coord_t'(cx + dx1),
			coord_t'(cy + dy1), coord_t'(cx - dx2), coord_t'(cy - dy2),
			coord_t'(cx + dx2), coord_t'(cy + dy2));
	endtask

	localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	initial begin
		int span;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		calm = 1'b0;
		stim_done = 1'b0;
		{a_start_x, a_start_y, a_end_x, a_end_y} = '0;
		{b_start_x, b_start_y, b_end_x, b_end_y} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plain cross, endpoint touches, parallel, collinear, degenerate, extremes.
		send_pair(-256, 0, 256, 0, 0, -256, 0, 256);
		send_pair(0, 0, 256, 256, 256, 256, 512, 0);
		send_pair(0, 0, 256, 0, 256, 0, 256, 256);
		send_pair(0, 0, 256, 0, 0, 256, 256, 256);
		send_pair(0, 0, 256, 0, 512, 0, 768, 0);
		send_pair(0, 0, 512, 0, 256, 0, 768, 0);
		send_pair(100, 100, 100, 100, 0, 0, 256, 256);
		send_pair(0, 0, 256, 256, 300, 300, 300, 300);
		send_pair(0, 0, 256, 0, 512, -256, 512, 256);
		send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
		send_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
		send_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
		send_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
		send_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
		send_pair(0, 0, 3, 7, 0, 7, 3, 0);
		send_pair(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);
		send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
		send_pair(-1, -1, -1, -1, -1, -1, -1, -1);

		// Random: mostly crossing pairs, the rest noise; a calm stretch in the middle.
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 600 && n < 900);
			span = ($urandom_range(0, 3) == 0) ? 4000000 : 3000;
			if ($urandom_range(0, 3) != 0)
				send_crossing(span);
			else
				send_pair(rand_coord(span), rand_coord(span), rand_coord(span),
					rand_coord(span), rand_coord(span), rand_coord(span),
					rand_coord(span), rand_coord(span));
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Output side: random stall, checking each result transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(hit, hit_x, hit_y);
			out_stall <= !calm && ($urandom_range(0, 99) < 22);
		end
	end

	// Watchdog: count cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		while (!(stim_done && board.pending.size() == 0) && idle_cycles < WDOG_MAX)
			@(posedge clk);
		if (idle_cycles >= WDOG_MAX) begin
			$display("tb_segment_intersection_2d_unit: done, errors");
			$finish;
		end else begin
			repeat (LATENCY + 10) @(posedge clk);
			if (board.errors == 0)
				$display("tb_segment_intersection_2d_unit: done, clean");
			else
				$display("tb_segment_intersection_2d_unit: done, errors");
			$finish;
		end
	end
endmodule
`default_nettype wire
